// File: rtl/fbfb_pkg.sv
// Shared types and constants for the framebuffer fill and blit engine.
`timescale 1ns / 1ps

package fbfb_pkg;

    typedef logic [2:0] t_op;
    typedef logic signed [16:0] t_crd;
    typedef logic signed [15:0] t_fld;

    localparam t_op OP_CLEAR = 3'd0;
    localparam t_op OP_FILL  = 3'd1;
    localparam t_op OP_BEGIN = 3'd2;
    localparam t_op OP_BLIT  = 3'd3;
    localparam t_op OP_READ  = 3'd4;

    localparam logic CFG_SCR_W = 1'b0;
    localparam logic CFG_SCR_H = 1'b1;

    localparam logic [31:0] BLACK_OPAQUE = 32'hFF00_0000;
    localparam logic [7:0]  ALPHA_LIMIT  = 8'd128;

    localparam logic [8:0] SCR_W_RST = 9'd240;
    localparam logic [9:0] SCR_H_RST = 10'd320;

    typedef struct packed {
        logic active;
        t_crd sx;
        t_crd sy;
    } t_blit_pos;

endpackage

// File: rtl/fbfb_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module fbfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/fbfb_pix.sv
// Shared pixel unit: on-screen compare and frame store address.
`timescale 1ns / 1ps

module fbfb_pix #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 512
) (
    input  fbfb_pkg::t_crd                              i_px,
    input  fbfb_pkg::t_crd                              i_py,
    input  fbfb_pkg::t_crd                              i_aw,
    input  fbfb_pkg::t_crd                              i_ah,
    output logic                                        o_on,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]     o_addr
);
    import fbfb_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

    assign o_on = (i_px >= 17'sd0) && (i_py >= 17'sd0) && (i_px < i_aw) && (i_py < i_ah);

    assign o_addr = AW'(i_py[YW-1:0]) * AW'(MAX_WIDTH) + AW'(i_px[XW-1:0]);

endmodule

// File: rtl/fbfb_blit.sv
// Blit image origin, size and row-major position tracking.
`timescale 1ns / 1ps

module fbfb_blit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_step,
    input  fbfb_pkg::t_fld       i_x,
    input  fbfb_pkg::t_fld       i_y,
    input  fbfb_pkg::t_fld       i_w,
    input  fbfb_pkg::t_fld       i_h,
    output fbfb_pkg::t_blit_pos  o_pos
);
    import fbfb_pkg::*;

    t_fld r_ox, r_oy, r_bw, r_bh, r_col, r_row;
    t_fld n_col;

    assign n_col = r_col + 16'sd1;

    assign o_pos.active = (r_bw > 16'sd0) && (r_bh > 16'sd0) && (r_row < r_bh);
    assign o_pos.sx     = t_crd'(r_ox) + t_crd'(r_col);
    assign o_pos.sy     = t_crd'(r_oy) + t_crd'(r_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox  <= '0;
            r_oy  <= '0;
            r_bw  <= '0;
            r_bh  <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (i_load) begin
            r_ox  <= i_x;
            r_oy  <= i_y;
            r_bw  <= i_w;
            r_bh  <= i_h;
            r_col <= '0;
            r_row <= '0;
        end else if (i_step) begin
            if (n_col >= r_bw) begin
                r_col <= '0;
                r_row <= r_row + 16'sd1;
            end else begin
                r_col <= n_col;
            end
        end
    end

endmodule

// File: rtl/framebuffer_fill_and_blit.sv
// Framebuffer fill and blit engine top level.
// Command paths from accept: read goes S_CALC, S_RADDR, S_RDATA; blit pixel S_CALC, S_BWR;
// begin blit, unknown op and empty fill end in S_CALC; fill sweeps the clipped pixels and
// clear the whole store in S_SWEEP. One command at a time: busy drops with o_strobe, so the
// next word is accepted at the edge that ends the o_strobe cycle.
// Reset: clearing pass over all MAX_WIDTH*MAX_HEIGHT words writes opaque black, busy high.
// Results show for one cycle on o_strobe; the receiver cannot stall them.
`timescale 1ns / 1ps

module framebuffer_fill_and_blit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  fbfb_pkg::t_op        i_op,
    input  fbfb_pkg::t_fld       i_pos_x,
    input  fbfb_pkg::t_fld       i_pos_y,
    input  fbfb_pkg::t_fld       i_size_w,
    input  fbfb_pkg::t_fld       i_size_h,
    input  logic [31:0]          i_color,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_addr,
    input  logic [9:0]           i_cfg_wdata,
    output logic                 o_strobe,
    output logic [31:0]          o_read_color,
    output logic                 o_in_range,
    output logic                 o_pixel_written
);
    import fbfb_pkg::*;

    localparam int   DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int   ADDR_W = $clog2(DEPTH);
    localparam t_crd MAXW_C = t_crd'(MAX_WIDTH);
    localparam t_crd MAXH_C = t_crd'(MAX_HEIGHT);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CALC  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_BWR   = 3'd3;
    localparam logic [2:0] S_RADDR = 3'd4;
    localparam logic [2:0] S_RDATA = 3'd5;

    logic [2:0]  r_state, n_state;
    logic        r_init, n_init;
    t_op         r_op;
    t_fld        r_x, r_y, r_w, r_h;
    logic [31:0] r_color, n_color;
    t_crd        r_px, n_px, r_py, n_py;
    t_crd        r_x0, n_x0, r_x1, n_x1, r_y1, n_y1;
    logic        r_rinr, n_rinr;
    logic [8:0]  r_scr_w;
    logic [9:0]  r_scr_h;
    logic        r_strobe, n_strobe;
    logic [31:0] r_rd, n_rd;
    logic        r_inr, n_inr;
    logic        r_wr, n_wr;

    t_crd        aw, ah;
    t_crd        fx0, fy0, fx1, fy1, fxe, fye;
    logic        pix_on;
    logic [ADDR_W-1:0] pix_addr;
    logic        mem_we;
    logic [31:0] mem_rdata;
    logic        blit_load, blit_step;
    t_blit_pos   blit_pos;
    logic        alpha_ok;
    logic        last_col, last_row;

    assign aw = (t_crd'({8'b0, r_scr_w}) > MAXW_C) ? MAXW_C : t_crd'({8'b0, r_scr_w});
    assign ah = (t_crd'({7'b0, r_scr_h}) > MAXH_C) ? MAXH_C : t_crd'({7'b0, r_scr_h});

    assign fx0 = (r_x < 16'sd0) ? 17'sd0 : t_crd'(r_x);
    assign fy0 = (r_y < 16'sd0) ? 17'sd0 : t_crd'(r_y);
    assign fxe = t_crd'(r_x) + t_crd'(r_w);
    assign fye = t_crd'(r_y) + t_crd'(r_h);
    assign fx1 = (fxe > aw) ? aw : fxe;
    assign fy1 = (fye > ah) ? ah : fye;

    assign alpha_ok = r_color[31:24] > ALPHA_LIMIT;
    assign last_col = (r_px + 17'sd1) >= r_x1;
    assign last_row = (r_py + 17'sd1) >= r_y1;

    assign busy = (r_state != S_IDLE);

    fbfb_pix #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pix (
        .i_px   (r_px),
        .i_py   (r_py),
        .i_aw   (aw),
        .i_ah   (ah),
        .o_on   (pix_on),
        .o_addr (pix_addr)
    );

    assign mem_we = (r_state == S_SWEEP) || ((r_state == S_BWR) && pix_on && alpha_ok);

    fbfb_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (pix_addr),
        .i_wdata (r_color),
        .o_rdata (mem_rdata)
    );

    assign blit_load = (r_state == S_CALC) && (r_op == OP_BEGIN);
    assign blit_step = (r_state == S_CALC) && (r_op == OP_BLIT) && blit_pos.active;

    fbfb_blit u_blit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (blit_load),
        .i_step  (blit_step),
        .i_x     (r_x),
        .i_y     (r_y),
        .i_w     (r_w),
        .i_h     (r_h),
        .o_pos   (blit_pos)
    );

    always_comb begin
        n_state  = r_state;
        n_init   = r_init;
        n_color  = r_color;
        n_px     = r_px;
        n_py     = r_py;
        n_x0     = r_x0;
        n_x1     = r_x1;
        n_y1     = r_y1;
        n_rinr   = r_rinr;
        n_strobe = 1'b0;
        n_rd     = r_rd;
        n_inr    = r_inr;
        n_wr     = r_wr;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CALC;
                    n_color = i_color;
                end
            end
            S_CALC: begin
                n_rd  = '0;
                n_inr = 1'b0;
                n_wr  = 1'b0;
                case (r_op)
                    OP_CLEAR: begin
                        n_px    = '0;
                        n_py    = '0;
                        n_x0    = '0;
                        n_x1    = MAXW_C;
                        n_y1    = MAXH_C;
                        n_color = BLACK_OPAQUE;
                        n_state = S_SWEEP;
                    end
                    OP_FILL: begin
                        if ((fx0 < fx1) && (fy0 < fy1)) begin
                            n_px    = fx0;
                            n_py    = fy0;
                            n_x0    = fx0;
                            n_x1    = fx1;
                            n_y1    = fy1;
                            n_state = S_SWEEP;
                        end else begin
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    OP_BLIT: begin
                        if (blit_pos.active) begin
                            n_px    = blit_pos.sx;
                            n_py    = blit_pos.sy;
                            n_state = S_BWR;
                        end else begin
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    OP_READ: begin
                        n_px    = t_crd'(r_x);
                        n_py    = t_crd'(r_y);
                        n_state = S_RADDR;
                    end
                    default: begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                endcase
            end
            S_SWEEP: begin
                if (last_col) begin
                    n_px = r_x0;
                    n_py = r_py + 17'sd1;
                end else begin
                    n_px = r_px + 17'sd1;
                end
                if (last_col && last_row) begin
                    n_state  = S_IDLE;
                    n_init   = 1'b0;
                    n_strobe = !r_init;
                    n_rd     = '0;
                    n_inr    = 1'b0;
                    n_wr     = 1'b0;
                end
            end
            S_BWR: begin
                n_inr    = pix_on;
                n_wr     = pix_on && alpha_ok;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_RADDR: begin
                n_rinr  = pix_on;
                n_state = S_RDATA;
            end
            S_RDATA: begin
                n_inr    = r_rinr;
                n_rd     = r_rinr ? mem_rdata : 32'h0;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_init   <= 1'b1;
            r_color  <= BLACK_OPAQUE;
            r_px     <= '0;
            r_py     <= '0;
            r_x0     <= '0;
            r_x1     <= MAXW_C;
            r_y1     <= MAXH_C;
            r_rinr   <= 1'b0;
            r_strobe <= 1'b0;
            r_rd     <= '0;
            r_inr    <= 1'b0;
            r_wr     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_color  <= n_color;
            r_px     <= n_px;
            r_py     <= n_py;
            r_x0     <= n_x0;
            r_x1     <= n_x1;
            r_y1     <= n_y1;
            r_rinr   <= n_rinr;
            r_strobe <= n_strobe;
            r_rd     <= n_rd;
            r_inr    <= n_inr;
            r_wr     <= n_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op <= i_op;
            r_x  <= i_pos_x;
            r_y  <= i_pos_y;
            r_w  <= i_size_w;
            r_h  <= i_size_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= SCR_W_RST;
            r_scr_h <= SCR_H_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SCR_W: r_scr_w <= i_cfg_wdata[8:0];
                CFG_SCR_H: r_scr_h <= i_cfg_wdata;
                default:   r_scr_w <= r_scr_w;
            endcase
        end
    end

    assign o_strobe        = r_strobe;
    assign o_read_color    = r_rd;
    assign o_in_range      = r_inr;
    assign o_pixel_written = r_wr;

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_pixel_written |-> o_in_range)
        else $error("written pixel reported off screen");

    a_rd_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_in_range |-> o_read_color == 32'h0)
        else $error("off-screen word carries read data");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> busy)
        else $error("frame store written while idle");

endmodule
